// ===== design/tlbs_pkg.sv =====
// package for the table search block: sizes, action codes, sequencer states
`timescale 1ns / 1ps

package tlbs_pkg;

    // table geometry
    localparam int DEPTH  = 256;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = 8;
    localparam int DATA_W = 32;
    localparam int ACT_W  = 2;

    // action codes
    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND = 2'd0,
        ACT_LINEAR = 2'd1,
        ACT_BINARY = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LIN,
        ST_BIN,
        ST_PUT
    } state_t;

endpackage

// ===== design/tlbs_req_if.sv =====
// request channel interface: action and value with valid/ready
`timescale 1ns / 1ps

interface tlbs_req_if
    import tlbs_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [ACT_W-1:0]         action;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

// ===== design/tlbs_rsp_if.sv =====
// response channel interface: found, index, overflow with valid/ready
`timescale 1ns / 1ps

interface tlbs_rsp_if
    import tlbs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             found;
    logic [IDX_W-1:0] index;
    logic             overflow;

    modport source (output valid, output found, output index, output overflow, input ready);
    modport sink   (input valid, input found, input index, input overflow, output ready);
endinterface

// ===== design/table_linear_binary_search.sv =====
// Table of signed 32-bit elements with append, linear search and binary search.
// The table sits in one synchronous single-port memory (read data registered, one
// read or one write per cycle); the element count resets to zero, entries are not
// cleared. One request is worked at a time and its result goes to an output
// register, so the next request is taken while the result still waits. An append,
// a search of an empty table and an unused action go straight to the result. Linear
// search reads entries from index 0 upward, one memory read per cycle, until a hit
// or the last used entry; binary search narrows the range with one probe read per cycle.
`timescale 1ns / 1ps

module table_linear_binary_search
    import tlbs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tlbs_req_if.sink    req,
    tlbs_rsp_if.source  rsp
);

    // element memory
    logic signed [DATA_W-1:0] mem [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic                     wr_en;

    // control and working registers
    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         used_reg, used_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic [ADDR_W-1:0]        ptr_reg, ptr_next;
    logic [CNT_W-1:0]         lo_reg, lo_next;
    logic [CNT_W-1:0]         hix_reg, hix_next;
    logic                     res_found_reg, res_found_next;
    logic [IDX_W-1:0]         res_index_reg, res_index_next;
    logic                     res_ovf_reg, res_ovf_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     out_found_reg, out_found_next;
    logic [IDX_W-1:0]         out_index_reg, out_index_next;
    logic                     out_ovf_reg, out_ovf_next;

    logic                     req_xfer;
    logic [CNT_W-1:0]         lin_next_cnt;
    logic [CNT_W-1:0]         bin_lo, bin_hix, bin_mid;
    logic [CNT_W-1:0]         first_mid;

    // midpoint of [lo, hix - 1], rounding down; caller ensures lo < hix
    function automatic logic [CNT_W-1:0] midpoint(input logic [CNT_W-1:0] lo,
                                                  input logic [CNT_W-1:0] hix);
        logic [CNT_W-1:0] span;
        span = hix - lo - CNT_W'(1);
        return lo + (span >> 1);
    endfunction

    assign req.ready    = (state_reg == ST_IDLE);
    assign req_xfer     = req.valid && req.ready;
    assign lin_next_cnt = {1'b0, ptr_reg} + CNT_W'(1);

    // first binary probe over the whole used range
    assign first_mid    = midpoint(CNT_W'(0), used_reg);

    // binary range after a probe miss
    always_comb
    begin
        bin_lo  = lo_reg;
        bin_hix = hix_reg;
        if (rd_data_reg < key_reg)
        begin
            bin_lo = {1'b0, ptr_reg} + CNT_W'(1);
        end
        else
        begin
            bin_hix = {1'b0, ptr_reg};
        end
        bin_mid = midpoint(bin_lo, bin_hix);
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        key_next       = key_reg;
        ptr_next       = ptr_reg;
        lo_next        = lo_reg;
        hix_next       = hix_reg;
        res_found_next = res_found_reg;
        res_index_next = res_index_reg;
        res_ovf_next   = res_ovf_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_index_next = out_index_reg;
        out_ovf_next   = out_ovf_reg;
        rd_en          = 1'b0;
        rd_addr        = ptr_reg;
        wr_en          = 1'b0;

        // output register drains on transfer
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    key_next       = req.value;
                    res_found_next = 1'b0;
                    res_index_next = '0;
                    res_ovf_next   = 1'b0;
                    state_next     = ST_PUT;
                    unique case (action_t'(req.action))
                        ACT_APPEND:
                        begin
                            if (used_reg == CNT_W'(DEPTH))
                            begin
                                res_ovf_next = 1'b1;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                used_next = used_reg + CNT_W'(1);
                            end
                        end
                        ACT_LINEAR:
                        begin
                            if (used_reg != '0)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = '0;
                                ptr_next   = '0;
                                state_next = ST_LIN;
                            end
                        end
                        ACT_BINARY:
                        begin
                            if (used_reg != '0)
                            begin
                                lo_next    = '0;
                                hix_next   = used_reg;
                                rd_en      = 1'b1;
                                rd_addr    = first_mid[ADDR_W-1:0];
                                ptr_next   = rd_addr;
                                state_next = ST_BIN;
                            end
                        end
                        default:
                        begin
                            state_next = ST_PUT;
                        end
                    endcase
                end
            end

            ST_LIN:
            begin
                if (rd_data_reg == key_reg)
                begin
                    res_found_next = 1'b1;
                    res_index_next = IDX_W'(ptr_reg);
                    state_next     = ST_PUT;
                end
                else if (lin_next_cnt == used_reg)
                begin
                    state_next = ST_PUT;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = lin_next_cnt[ADDR_W-1:0];
                    ptr_next = rd_addr;
                end
            end

            ST_BIN:
            begin
                if (rd_data_reg == key_reg)
                begin
                    res_found_next = 1'b1;
                    res_index_next = IDX_W'(ptr_reg);
                    state_next     = ST_PUT;
                end
                else if (bin_lo < bin_hix)
                begin
                    lo_next  = bin_lo;
                    hix_next = bin_hix;
                    rd_en    = 1'b1;
                    rd_addr  = bin_mid[ADDR_W-1:0];
                    ptr_next = rd_addr;
                end
                else
                begin
                    state_next = ST_PUT;
                end
            end

            ST_PUT:
            begin
                // load the result once the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_index_next = res_index_reg;
                    out_ovf_next   = res_ovf_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[used_reg[ADDR_W-1:0]] <= req.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        ptr_reg       <= ptr_next;
        lo_reg        <= lo_next;
        hix_reg       <= hix_next;
        res_found_reg <= res_found_next;
        res_index_reg <= res_index_next;
        res_ovf_reg   <= res_ovf_next;
        out_found_reg <= out_found_next;
        out_index_reg <= out_index_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.found    = out_found_reg;
    assign rsp.index    = out_index_reg;
    assign rsp.overflow = out_ovf_reg;

endmodule

// ===== design/tlbs_checker.sv =====
// port-level checker for the table search block and its bind
`timescale 1ns / 1ps

module tlbs_checker
    import tlbs_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input logic             rsp_found,
    input logic [IDX_W-1:0] rsp_index,
    input logic             rsp_overflow
);

    // a stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            $stable(rsp_found) && $stable(rsp_index) && $stable(rsp_overflow))
        else $error("result payload changed while stalled");

    // a hit and an overflow never come together
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_found && rsp_overflow))
        else $error("found and overflow both set");

    // a miss reports index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_found |-> rsp_index == '0)
        else $error("nonzero index without a hit");

    // one request at a time: busy right after a request transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one in progress");

endmodule

bind table_linear_binary_search tlbs_checker u_tlbs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_found    (rsp.found),
    .rsp_index    (rsp.index),
    .rsp_overflow (rsp.overflow)
);

// ===== tb/sv/tb.sv =====
// testbench for table_linear_binary_search: queue-fed driver, monitor and table predictor
`timescale 1ns / 1ps

module tb;
    import tlbs_pkg::*;

    typedef struct {
        action_t                  act;
        logic signed [DATA_W-1:0] value;
    } request_t;

    typedef struct {
        logic             found;
        logic [IDX_W-1:0] index;
        logic             overflow;
    } answer_t;

    logic clk;
    logic rst_n;

    tlbs_req_if req_ch ();
    tlbs_rsp_if rsp_ch ();

    table_linear_binary_search dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // stimulus and expectations
    request_t requests_todo[$];
    answer_t  answers_due[$];

    // generator view of the table contents, used to pick search keys
    logic signed [DATA_W-1:0] gen_vals[$];

    // predictor state
    logic signed [DATA_W-1:0] shadow_tbl [DEPTH];
    int                       shadow_used;

    int   total_items;
    int   phase1_at;
    int   phase2_at;
    int   req_count;
    int   rsp_count;
    int   errors;
    int   n_append;
    int   n_linear;
    int   n_binary;
    int   n_hits;
    int   n_overflow;
    logic req_fire;
    int   stall_left;
    logic stall_done;

    // clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // predicted answer for one accepted request, updates the shadow table
    function automatic answer_t table_answer(action_t act, logic signed [DATA_W-1:0] key);
        answer_t ans;
        int      lo;
        int      hi;
        int      mid;
        logic    done;
        ans.found    = 1'b0;
        ans.index    = '0;
        ans.overflow = 1'b0;
        done         = 1'b0;
        case (act)
            ACT_APPEND:
            begin
                if (shadow_used < DEPTH)
                begin
                    shadow_tbl[shadow_used] = key;
                    shadow_used++;
                end
                else
                begin
                    ans.overflow = 1'b1;
                end
            end
            ACT_LINEAR:
            begin
                for (int i = 0; i < shadow_used && !done; i++)
                begin
                    if (shadow_tbl[i] == key)
                    begin
                        ans.found = 1'b1;
                        ans.index = i[IDX_W-1:0];
                        done      = 1'b1;
                    end
                end
            end
            ACT_BINARY:
            begin
                lo = 0;
                hi = shadow_used - 1;
                while (lo <= hi && !done)
                begin
                    mid = lo + (hi - lo) / 2;
                    if (shadow_tbl[mid] == key)
                    begin
                        ans.found = 1'b1;
                        ans.index = mid[IDX_W-1:0];
                        done      = 1'b1;
                    end
                    else if (shadow_tbl[mid] < key)
                    begin
                        lo = mid + 1;
                    end
                    else
                    begin
                        hi = mid - 1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return ans;
    endfunction

    task automatic push_req(action_t act, logic signed [DATA_W-1:0] val);
        request_t r;
        r.act   = act;
        r.value = val;
        requests_todo.insert(requests_todo.size(), r);
        if (act == ACT_APPEND && gen_vals.size() < DEPTH)
        begin
            gen_vals.insert(gen_vals.size(), val);
        end
    endtask

    // mostly keys that are stored, some neighbors, some random
    function automatic logic signed [DATA_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 99);
        if (gen_vals.size() == 0 || sel < 20)
        begin
            return $urandom;
        end
        else if (sel < 30)
        begin
            return gen_vals[$urandom_range(0, gen_vals.size() - 1)] + 1;
        end
        return gen_vals[$urandom_range(0, gen_vals.size() - 1)];
    endfunction

    // stimulus, reset and end of run
    initial
    begin
        int                       counted;
        int                       sel;
        logic signed [DATA_W-1:0] cur;
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.action      = ACT_NONE;
        req_ch.value       = '0;
        rsp_ch.ready       = 1'b0;
        errors             = 0;
        req_count          = 0;
        rsp_count          = 0;
        n_append           = 0;
        n_linear           = 0;
        n_binary           = 0;
        n_hits             = 0;
        n_overflow         = 0;
        shadow_used        = 0;

        // directed: empty table, unused action, extremes, duplicates
        push_req(ACT_LINEAR, 32'sd5);
        push_req(ACT_BINARY, 32'sd5);
        push_req(ACT_NONE, 32'hFFFF_FFFF);
        push_req(ACT_APPEND, 32'h8000_0000);
        push_req(ACT_APPEND, -32'sd5);
        push_req(ACT_APPEND, 32'sd0);
        push_req(ACT_APPEND, 32'sd7);
        push_req(ACT_LINEAR, 32'h8000_0000);
        push_req(ACT_LINEAR, 32'sd7);
        push_req(ACT_LINEAR, 32'sd0);
        push_req(ACT_LINEAR, 32'sd100);
        push_req(ACT_LINEAR, 32'h7FFF_FFFF);
        push_req(ACT_BINARY, 32'h8000_0000);
        push_req(ACT_BINARY, -32'sd5);
        push_req(ACT_BINARY, 32'sd0);
        push_req(ACT_BINARY, 32'sd7);
        push_req(ACT_BINARY, 32'sd3);
        push_req(ACT_BINARY, 32'h7FFF_FFFF);
        push_req(ACT_APPEND, 32'sd7);
        push_req(ACT_LINEAR, 32'sd7);
        push_req(ACT_BINARY, 32'sd7);
        push_req(ACT_NONE, 32'sd0);

        // random: ascending fill with some noise, searches mixed in, then a full table
        cur     = 32'sd8;
        counted = 0;
        while (counted < 950 || gen_vals.size() < DEPTH)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 5)
            begin
                push_req(ACT_NONE, $urandom);
                counted++;
            end
            else if ((gen_vals.size() < DEPTH && sel < 40) || sel < 10)
            begin
                if (gen_vals.size() == DEPTH - 1)
                begin
                    push_req(ACT_APPEND, 32'h7FFF_FFFF);
                end
                else if ($urandom_range(0, 19) == 0)
                begin
                    push_req(ACT_APPEND, $urandom);
                end
                else
                begin
                    if ($urandom_range(0, 9) != 0)
                    begin
                        cur = cur + $urandom_range(1, 1 << 22);
                    end
                    push_req(ACT_APPEND, cur);
                end
                counted++;
            end
            else if (sel < 55)
            begin
                push_req(ACT_LINEAR, pick_key());
                counted++;
            end
            else
            begin
                push_req(ACT_BINARY, pick_key());
                counted++;
            end
        end
        push_req(ACT_APPEND, $urandom);
        push_req(ACT_LINEAR, 32'h7FFF_FFFF);
        push_req(ACT_BINARY, 32'h7FFF_FFFF);

        total_items = requests_todo.size();
        phase1_at   = total_items / 3;
        phase2_at   = 2 * total_items / 3;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (req_count < total_items || answers_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (300) @(posedge clk);
        if (answers_due.size() != 0)
        begin
            $error("results still outstanding: %0d", answers_due.size());
            errors++;
        end

        $display("requests: %0d appends (%0d dropped on full table), %0d linear, %0d binary",
                 n_append, n_overflow, n_linear, n_binary);
        $display("results checked: %0d, search hits: %0d", rsp_count, n_hits);
        if (errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    // request driver: new transfer offered at the falling edge
    always @(negedge clk)
    begin
        int       send_idle;
        request_t r;
        send_idle = (req_count < phase1_at) ? 16 : (req_count < phase2_at) ? 74 : 0;
        if (rst_n)
        begin
            if (!req_ch.valid || req_fire)
            begin
                if (requests_todo.size() > 0 && $urandom_range(0, 99) >= send_idle)
                begin
                    r = requests_todo.pop_front();
                    req_ch.valid  <= 1'b1;
                    req_ch.action <= r.act;
                    req_ch.value  <= r.value;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // response receiver: random back-pressure plus one long hold-off
    always @(negedge clk)
    begin
        int recv_idle;
        recv_idle = (req_count < phase1_at) ? 74 : (req_count < phase2_at) ? 16 : 0;
        if (!rst_n)
        begin
            stall_left <= 0;
            stall_done <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (!stall_done && req_count >= phase2_at + 40)
        begin
            stall_done   <= 1'b1;
            stall_left   <= 400;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // monitor: predict on request transfer, check on response transfer
    always @(posedge clk or negedge rst_n)
    begin
        answer_t exp_ans;
        action_t act;
        if (!rst_n)
        begin
            req_fire <= 1'b0;
        end
        else
        begin
            req_fire <= req_ch.valid && req_ch.ready;
            if (req_ch.valid && req_ch.ready)
            begin
                act     = action_t'(req_ch.action);
                exp_ans = table_answer(act, req_ch.value);
                answers_due.insert(answers_due.size(), exp_ans);
                req_count++;
                if (act == ACT_APPEND)
                begin
                    n_append++;
                end
                if (act == ACT_LINEAR)
                begin
                    n_linear++;
                end
                if (act == ACT_BINARY)
                begin
                    n_binary++;
                end
                if (exp_ans.found)
                begin
                    n_hits++;
                end
                if (exp_ans.overflow)
                begin
                    n_overflow++;
                end
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                rsp_count++;
                if (answers_due.size() == 0)
                begin
                    $error("result transfer with no result expected");
                    errors++;
                end
                else
                begin
                    exp_ans = answers_due.pop_front();
                    if (rsp_ch.found !== exp_ans.found)
                    begin
                        $error("found: expected %0d, got %0d", exp_ans.found, rsp_ch.found);
                        errors++;
                    end
                    if (rsp_ch.index !== exp_ans.index)
                    begin
                        $error("index: expected %0d, got %0d", exp_ans.index, rsp_ch.index);
                        errors++;
                    end
                    if (rsp_ch.overflow !== exp_ans.overflow)
                    begin
                        $error("overflow: expected %0d, got %0d", exp_ans.overflow,
                               rsp_ch.overflow);
                        errors++;
                    end
                end
            end
        end
    end

endmodule
